// ===== rtl/completion_due_time_predictor_core_assert.svh =====
// Assertion macros for the completion due-time predictor.
// Needs nothing but the clock and reset names handed to each use.
`ifndef COMPLETION_DUE_TIME_PREDICTOR_CORE_ASSERT_SVH
`define COMPLETION_DUE_TIME_PREDICTOR_CORE_ASSERT_SVH

// same-cycle implication
`define CDTP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cdtp assertion failed");

// next-cycle implication
`define CDTP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cdtp assertion failed");

`endif

// ===== rtl/cdtp_pkg.sv =====
// Shared types and constants of the completion due-time predictor.
// No dependencies.
package cdtp_pkg;

    localparam int TIME_BITS_DEF = 64;
    localparam int MILLE_BITS    = 10;
    localparam int MILLE         = 1000;
    localparam int RATE_BITS     = 63;

    localparam logic [1:0] ST_RUNNING  = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd2;

    typedef enum logic [1:0] {
        KIND_DONE,
        KIND_STALL,
        KIND_ERR,
        KIND_RUN
    } kind_t;

    typedef struct packed {
        logic [1:0]         proc_state;
        logic [63:0]        proc_ident;
        logic [63:0]        last_eval_time;
        logic [63:0]        work_left;
        logic signed [63:0] rate_mille;
        logic [63:0]        earliest_time;
    } in_item_t;

    typedef struct packed {
        logic        event_present;
        logic        error_code;
        logic [63:0] due_tick;
        logic [63:0] event_ident;
        logic [63:0] expected_eval;
    } out_item_t;

    // side data that rides along the divider
    typedef struct packed {
        kind_t       kind;
        logic [63:0] ident;
        logic [63:0] last;
        logic [63:0] nb;
        logic [63:0] stall_due;
    } side_t;

endpackage

// ===== rtl/completion_due_time_predictor_core.sv =====
// Top level of the completion due-time predictor: pipeline, output skid.
// Uses cdtp_pkg, cdtp_prep, cdtp_div_step, cdtp_fin and the assert header.
//
//  channel  | ports                      | payload
//  ---------+----------------------------+----------------------
//  input    | s_valid / s_ready / s_data | cdtp_pkg::in_item_t
//  result   | m_valid / m_ready / m_data | cdtp_pkg::out_item_t
//  config   | cfg_wr_en / cfg_wr_data    | stall interval, 64 b
//
// One item per cycle sustained while the skid item is empty; one entry
// stage, TIME_BITS + 10 divider stages at one quotient bit each, two
// finishing stages, then the output register.
// aresetn is synchronous: it clears the valid bits and sets the stall
// interval to 1.
// The pipe moves as one while the skid item is empty; a result the sink
// does not take parks in the skid, and only then does s_ready drop.
module completion_due_time_predictor_core #(
    parameter int TIME_BITS = cdtp_pkg::TIME_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cdtp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cdtp_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  logic [63:0]         cfg_wr_data
);
`include "completion_due_time_predictor_core_assert.svh"

    // W*1000 is at most TIME_BITS+10 bits: one divider stage per bit
    localparam int DW = TIME_BITS + cdtp_pkg::MILLE_BITS;

    logic [63:0]         stall_reg;
    logic                pipe_en;
    logic                skid_vld_reg;
    cdtp_pkg::out_item_t skid_reg;
    logic                m_valid_reg;
    cdtp_pkg::out_item_t m_data_reg;

    // stage k holds the item after k divider steps
    logic                           st_vld  [0:DW];
    cdtp_pkg::side_t                st_side [0:DW];
    logic [DW-1:0]                  st_dq   [0:DW];
    logic [cdtp_pkg::RATE_BITS-1:0] st_rem  [0:DW];
    logic [cdtp_pkg::RATE_BITS-1:0] st_div  [0:DW];

    logic                fin_vld;
    cdtp_pkg::out_item_t fin_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stall_reg <= 64'd1;
        end else if (cfg_wr_en) begin
            stall_reg <= cfg_wr_data;
        end
    end

    assign pipe_en = !skid_vld_reg;
    assign s_ready = pipe_en;

    cdtp_prep #(.TIME_BITS(TIME_BITS)) u_prep (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (pipe_en),
        .in_vld         (s_valid),
        .in_data        (s_data),
        .stall_interval (stall_reg),
        .vld_reg        (st_vld[0]),
        .side_reg       (st_side[0]),
        .dq_reg         (st_dq[0]),
        .div_reg        (st_div[0])
    );
    // remainder starts at zero
    assign st_rem[0] = '0;

    for (genvar k = 0; k < DW; k++) begin : g_div
        cdtp_div_step #(.DW(DW)) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (pipe_en),
            .vld      (st_vld[k]),
            .side     (st_side[k]),
            .dq       (st_dq[k]),
            .rem      (st_rem[k]),
            .div      (st_div[k]),
            .vld_reg  (st_vld[k+1]),
            .side_reg (st_side[k+1]),
            .dq_reg   (st_dq[k+1]),
            .rem_reg  (st_rem[k+1]),
            .div_reg  (st_div[k+1])
        );
    end

    cdtp_fin #(.TIME_BITS(TIME_BITS)) u_fin (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .vld      (st_vld[DW]),
        .side     (st_side[DW]),
        .quo      (st_dq[DW]),
        .rem      (st_rem[DW]),
        .vld_reg  (fin_vld),
        .item_reg (fin_item)
    );

    // output register plus one skid item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            if (skid_vld_reg) begin
                m_valid_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                m_valid_reg <= fin_vld;
            end
        end else if (pipe_en && fin_vld) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_data_reg <= skid_vld_reg ? skid_reg : fin_item;
        end else if (pipe_en && fin_vld) begin
            skid_reg <= fin_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a parked item always has a result in front of it
    `CDTP_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_vld_reg, m_valid_reg)
    // draining the skid leaves the output full and the skid empty
    `CDTP_ASSERT_NEXT(a_skid_drain, aclk, aresetn, skid_vld_reg && m_ready,
        m_valid_reg && !skid_vld_reg)
    // an error result never carries an event
    `CDTP_ASSERT_NOW(a_err_no_event, aclk, aresetn, m_valid_reg && m_data_reg.error_code,
        !m_data_reg.event_present)
    // an event is never due before the evaluation it expects
    `CDTP_ASSERT_NOW(a_due_after_eval, aclk, aresetn,
        m_valid_reg && m_data_reg.event_present,
        m_data_reg.due_tick >= m_data_reg.expected_eval)

endmodule

// ===== rtl/cdtp_prep.sv =====
// Entry stage: decode, masking, stall due time and work x 1000.
// Uses cdtp_pkg.
module cdtp_prep #(
    parameter int TIME_BITS = cdtp_pkg::TIME_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_vld,
    input  cdtp_pkg::in_item_t                     in_data,
    input  logic [63:0]                            stall_interval,
    output logic                                   vld_reg,
    output cdtp_pkg::side_t                        side_reg,
    output logic [TIME_BITS+cdtp_pkg::MILLE_BITS-1:0] dq_reg,
    output logic [cdtp_pkg::RATE_BITS-1:0]         div_reg
);
    localparam int DW = TIME_BITS + cdtp_pkg::MILLE_BITS;

    logic [TIME_BITS-1:0]     last_t, nb_t, work_t, stall_t, anchor;
    logic [TIME_BITS:0]       ssum;
    logic                     rate_pos;
    cdtp_pkg::side_t          side_next;
    logic [DW-1:0]            dq_next;

    always_comb begin
        last_t   = in_data.last_eval_time[TIME_BITS-1:0];
        nb_t     = in_data.earliest_time[TIME_BITS-1:0];
        work_t   = in_data.work_left[TIME_BITS-1:0];
        stall_t  = stall_interval[TIME_BITS-1:0];
        rate_pos = (in_data.rate_mille != '0) && !in_data.rate_mille[63];
        anchor   = (last_t > nb_t) ? last_t : nb_t;
        ssum     = {1'b0, anchor} + {1'b0, stall_t};

        side_next.ident     = in_data.proc_ident;
        side_next.last      = 64'(last_t);
        side_next.nb        = 64'(nb_t);
        side_next.stall_due = ssum[TIME_BITS] ? 64'({TIME_BITS{1'b1}})
                                              : 64'(ssum[TIME_BITS-1:0]);
        if (in_data.proc_state == cdtp_pkg::ST_COMPLETE) begin
            side_next.kind = cdtp_pkg::KIND_DONE;
        end else if (in_data.proc_state != cdtp_pkg::ST_RUNNING || !rate_pos) begin
            side_next.kind = cdtp_pkg::KIND_STALL;
        end else if (work_t == '0) begin
            side_next.kind = cdtp_pkg::KIND_ERR;
        end else begin
            side_next.kind = cdtp_pkg::KIND_RUN;
        end
        dq_next = {{cdtp_pkg::MILLE_BITS{1'b0}}, work_t} * DW'(cdtp_pkg::MILLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_next;
            dq_reg   <= dq_next;
            div_reg  <= in_data.rate_mille[cdtp_pkg::RATE_BITS-1:0];
        end
    end

endmodule

// ===== rtl/cdtp_div_step.sv =====
// One restoring-division step: one quotient bit per stage.
// Uses cdtp_pkg.
module cdtp_div_step #(
    parameter int DW = cdtp_pkg::TIME_BITS_DEF + cdtp_pkg::MILLE_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           vld,
    input  cdtp_pkg::side_t                side,
    input  logic [DW-1:0]                  dq,
    input  logic [cdtp_pkg::RATE_BITS-1:0] rem,
    input  logic [cdtp_pkg::RATE_BITS-1:0] div,
    output logic                           vld_reg,
    output cdtp_pkg::side_t                side_reg,
    output logic [DW-1:0]                  dq_reg,
    output logic [cdtp_pkg::RATE_BITS-1:0] rem_reg,
    output logic [cdtp_pkg::RATE_BITS-1:0] div_reg
);
    logic [cdtp_pkg::RATE_BITS:0]   rs, diff;
    logic                           ge;
    logic [cdtp_pkg::RATE_BITS-1:0] rem_next;
    logic [DW-1:0]                  dq_next;

    always_comb begin
        rs       = {rem, dq[DW-1]};
        diff     = rs - {1'b0, div};
        ge       = rs >= {1'b0, div};
        rem_next = ge ? diff[cdtp_pkg::RATE_BITS-1:0] : rs[cdtp_pkg::RATE_BITS-1:0];
        dq_next  = {dq[DW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side;
            dq_reg   <= dq_next;
            rem_reg  <= rem_next;
            div_reg  <= div;
        end
    end

endmodule

// ===== rtl/cdtp_fin.sv =====
// Last two stages: round up and saturate the tick count, then add,
// clamp to the not-before time and build the result item. Uses cdtp_pkg.
module cdtp_fin #(
    parameter int TIME_BITS = cdtp_pkg::TIME_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      en,
    input  logic                                      vld,
    input  cdtp_pkg::side_t                           side,
    input  logic [TIME_BITS+cdtp_pkg::MILLE_BITS-1:0] quo,
    input  logic [cdtp_pkg::RATE_BITS-1:0]            rem,
    output logic                                      vld_reg,
    output cdtp_pkg::out_item_t                       item_reg
);
    logic                 a_vld_reg;
    cdtp_pkg::side_t      a_side_reg;
    logic [TIME_BITS-1:0] ticks_reg, ticks_next;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] due;
    cdtp_pkg::out_item_t  item_next;

    always_comb begin
        ticks_next = (|quo[TIME_BITS+cdtp_pkg::MILLE_BITS-1:TIME_BITS])
                   ? {TIME_BITS{1'b1}} : quo[TIME_BITS-1:0];
        if (!(&ticks_next) && rem != '0) begin
            ticks_next = ticks_next + TIME_BITS'(1);
        end
    end

    always_comb begin
        sum = {1'b0, a_side_reg.last[TIME_BITS-1:0]} + {1'b0, ticks_reg};
        due = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
        if (due < a_side_reg.nb[TIME_BITS-1:0]) begin
            due = a_side_reg.nb[TIME_BITS-1:0];
        end
        item_next = '0;
        case (a_side_reg.kind)
            cdtp_pkg::KIND_DONE: begin
                item_next = '0;
            end
            cdtp_pkg::KIND_STALL: begin
                item_next.event_present = 1'b1;
                item_next.due_tick      = a_side_reg.stall_due;
                item_next.event_ident   = a_side_reg.ident;
                item_next.expected_eval = a_side_reg.last;
            end
            cdtp_pkg::KIND_ERR: begin
                item_next.error_code  = 1'b1;
                item_next.event_ident = a_side_reg.ident;
            end
            cdtp_pkg::KIND_RUN: begin
                item_next.event_present = 1'b1;
                item_next.due_tick      = 64'(due);
                item_next.event_ident   = a_side_reg.ident;
                item_next.expected_eval = a_side_reg.last;
            end
            default: begin
                item_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            vld_reg   <= 1'b0;
        end else if (en) begin
            a_vld_reg <= vld;
            vld_reg   <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg <= side;
            ticks_reg  <= ticks_next;
            item_reg   <= item_next;
        end
    end

endmodule
